[rtl/electronic_load_measurement_top_defines.svh]
// Assertion macros for the electronic load measurement block
`ifndef ELECTRONIC_LOAD_MEASUREMENT_TOP_DEFINES_SVH
`define ELECTRONIC_LOAD_MEASUREMENT_TOP_DEFINES_SVH

// property checked every cycle out of reset
`define ELM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// consequence in the cycle after the trigger
`define ELM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// consequence in the same cycle as the trigger
`define ELM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/elm_pkg.sv]
`default_nettype none

package elm_pkg;

    typedef struct packed {
        logic signed [23:0] raw_current;
        logic signed [23:0] raw_voltage;
    } t_in;

    typedef struct packed {
        logic signed [31:0] current_value;
        logic signed [31:0] voltage_value;
        logic               relay_one;
        logic               relay_two;
        logic [1:0]         calibration_band;
        logic signed [47:0] charge_value;
    } t_out;

    typedef struct packed {
        logic load;
        logic div_step;
        logic cal;
        logic cur;
        logic drop;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic use_div;
    } t_sts;

    // load modes
    localparam logic [1:0] MODE_CC = 2'd0;
    localparam logic [1:0] MODE_CP = 2'd1;
    localparam logic [1:0] MODE_CR = 2'd2;

    // register indexes
    localparam int         REG_IDX_W         = 2;
    localparam logic [1:0] REG_LOAD_MODE     = 2'd0;
    localparam logic [1:0] REG_SETPOINT      = 2'd1;
    localparam logic [1:0] REG_LOAD_ON       = 2'd2;
    localparam logic [1:0] REG_WIRE_RES      = 2'd3;

    // calibration bands
    localparam logic [1:0] BAND_LOW  = 2'd0;
    localparam logic [1:0] BAND_MID  = 2'd1;
    localparam logic [1:0] BAND_HIGH = 2'd2;
    localparam logic [1:0] BAND_OUT  = 2'd3;

    // divider: 48-bit dividend, 32-bit divisor, one quotient bit per cycle
    localparam int DIV_STEPS = 48;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // equivalent current limits, Q16.16
    localparam int                 EQ_W          = 50;
    localparam logic signed [49:0] EQ_LIM_LOW    = 50'sd327680;
    localparam logic signed [49:0] EQ_LIM_MID    = 50'sd655360;
    localparam logic signed [49:0] EQ_LIM_HIGH   = 50'sd983040;
    localparam logic signed [49:0] EQ_LIM_RELAY2 = 50'sd720896;

    // calibration in Q40
    localparam longint Q40      = 64'sd1 <<< 40;
    localparam longint GAIN0_L  = (64'sd1422 * Q40) / 64'sd88227700;
    localparam longint OFFS0_L  = (64'sd17 * Q40) / 64'sd100
                                  - (64'sd79133 * GAIN0_L) / 64'sd3;
    localparam longint GAIN1_L  = (64'sd5086667 * (64'sd1 <<< 34)) / 64'sd6545703125;
    localparam longint OFFS1_L  = (64'sd506667 * Q40) / 64'sd100000
                                  - (64'sd1000675 * GAIN1_L) / 64'sd3;
    localparam longint GAIN2_L  = (64'sd1032 * Q40) / 64'sd138375100;
    localparam longint OFFS2_L  = (64'sd1104 * Q40) / 64'sd100
                                  - (64'sd2566141 * GAIN2_L) / 64'sd3;
    localparam longint GAINV_L  = (64'sd14978 * Q40) / 64'sd29130860000;
    localparam longint OFFSV_L  = (64'sd11506 * Q40) / 64'sd1000 - 64'sd1838100 * GAINV_L;

    localparam int GAIN_W  = 26;
    localparam int OFFS_W  = 44;
    localparam int GAINV_W = 21;
    localparam int OFFSV_W = 45;

    localparam logic signed [GAIN_W-1:0]  GAIN0 = GAIN_W'(GAIN0_L);
    localparam logic signed [GAIN_W-1:0]  GAIN1 = GAIN_W'(GAIN1_L);
    localparam logic signed [GAIN_W-1:0]  GAIN2 = GAIN_W'(GAIN2_L);
    localparam logic signed [OFFS_W-1:0]  OFFS0 = OFFS_W'(OFFS0_L);
    localparam logic signed [OFFS_W-1:0]  OFFS1 = OFFS_W'(OFFS1_L);
    localparam logic signed [OFFS_W-1:0]  OFFS2 = OFFS_W'(OFFS2_L);
    localparam logic signed [GAINV_W-1:0] GAINV = GAINV_W'(GAINV_L);
    localparam logic signed [OFFSV_W-1:0] OFFSV = OFFSV_W'(OFFSV_L);

    // charge step: floor((cur + 10) / 20) as floor(floor((cur + 10) / 4) / 5),
    // the /5 by reciprocal on a biased non-negative value
    localparam logic [26:0] CHG_M    = 27'd107374183;
    localparam logic [26:0] CHG_BIAS = 27'd83886080;

endpackage

`default_nettype wire

[rtl/electronic_load_measurement_top.sv]
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_in_item   (elm_pkg::t_in)
// output    out        o_out_valid / i_out_ready  o_out_item  (elm_pkg::t_out)
// config    in         i_cfg_wr_en                i_cfg_index, i_cfg_data
//
// An item is accepted only once the previous item has finished. When the setpoint needs
// a division (constant power or constant resistance with a nonzero divisor), the
// 48-step restoring divider runs before the calibration, current, drop and final steps;
// otherwise the item goes straight to those steps.
// Synchronous active-low reset clears the registers, last voltage and charge.
// A result waits in the output register; the next item is accepted meanwhile
// and only its final step stalls until the output is taken.
`default_nettype none

`include "electronic_load_measurement_top_defines.svh"

module electronic_load_measurement_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  elm_pkg::t_in                       i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output elm_pkg::t_out                      o_out_item,
    input  logic                               i_cfg_wr_en,
    input  logic [elm_pkg::REG_IDX_W-1:0]      i_cfg_index,
    input  logic [31:0]                        i_cfg_data
);

    logic [1:0]    r_load_mode;
    logic [31:0]   r_setpoint;
    logic          r_load_on;
    logic [31:0]   r_wire_res;
    elm_pkg::t_cmd w_cmd;
    elm_pkg::t_sts w_sts;
    logic [5:0]    w_cmd_bits;
    logic          w_out_band;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_mode <= elm_pkg::MODE_CC;
            r_setpoint  <= '0;
            r_load_on   <= 1'b0;
            r_wire_res  <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                elm_pkg::REG_LOAD_MODE: r_load_mode <= i_cfg_data[1:0];
                elm_pkg::REG_SETPOINT:  r_setpoint  <= i_cfg_data;
                elm_pkg::REG_LOAD_ON:   r_load_on   <= i_cfg_data[0];
                elm_pkg::REG_WIRE_RES:  r_wire_res  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    elm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    elm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_item   (i_in_item),
        .i_load_mode (r_load_mode),
        .i_setpoint  (r_setpoint),
        .i_load_on   (r_load_on),
        .i_wire_res  (r_wire_res),
        .o_res       (o_out_item)
    );

    assign w_cmd_bits = w_cmd;
    assign w_out_band = o_out_valid && (o_out_item.calibration_band == elm_pkg::BAND_OUT);

    `ELM_ASSERT(a_cmd_onehot, $onehot0(w_cmd_bits), "overlapping datapath commands")
    `ELM_ASSERT_NEXT(a_accept_busy, i_in_valid && o_in_ready, !o_in_ready, "ready after accept")
    `ELM_ASSERT_NEXT(a_fin_valid, w_cmd.fin, o_out_valid, "finished item not presented")
    `ELM_ASSERT_SAME(a_out_band_zero, w_out_band, o_out_item.current_value == 32'sd0, "band 3 current")

endmodule

`default_nettype wire

[rtl/elm_ctrl.sv]
`default_nettype none

module elm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  elm_pkg::t_sts i_sts,
    output elm_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_CAL  = 3'd2;
    localparam logic [2:0] S_CUR  = 3'd3;
    localparam logic [2:0] S_DROP = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]               r_state;
    logic [2:0]               n_state;
    logic [elm_pkg::CNT_W-1:0] r_cnt;
    logic [elm_pkg::CNT_W-1:0] n_cnt;
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic                     w_accept;
    logic                     w_fire;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_fire      = !r_out_valid || i_out_ready;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = w_accept;
                n_cnt      = '0;
                if (w_accept) begin
                    n_state = i_sts.use_div ? S_DIV : S_CAL;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == elm_pkg::CNT_W'(elm_pkg::DIV_STEPS - 1)) begin
                    n_state = S_CAL;
                end
            end
            S_CAL: begin
                o_cmd.cal = 1'b1;
                n_state   = S_CUR;
            end
            S_CUR: begin
                o_cmd.cur = 1'b1;
                n_state   = S_DROP;
            end
            S_DROP: begin
                o_cmd.drop = 1'b1;
                n_state    = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = w_fire;
                if (w_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.fin) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

[rtl/elm_dp.sv]
`default_nettype none

module elm_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  elm_pkg::t_cmd i_cmd,
    output elm_pkg::t_sts o_sts,
    input  elm_pkg::t_in  i_in_item,
    input  logic [1:0]    i_load_mode,
    input  logic [31:0]   i_setpoint,
    input  logic          i_load_on,
    input  logic [31:0]   i_wire_res,
    output elm_pkg::t_out o_res
);

    // stored state
    logic signed [31:0] r_last_volt;
    logic signed [47:0] r_charge;

    // captured item
    logic signed [23:0] r_rc;
    logic signed [23:0] r_rv;

    // divider
    logic [47:0] r_num;
    logic [31:0] r_den;
    logic [31:0] r_rem;
    logic        r_neg;
    logic        r_use_div;

    // pipeline
    logic [1:0]          r_band;
    logic                r_rel1;
    logic                r_rel2;
    logic signed [49:0]  r_pcur;
    logic signed [44:0]  r_pvolt;
    logic signed [25:0]  r_cur;
    logic signed [21:0]  r_volt0;
    logic signed [58:0]  r_pdrop;
    logic [53:0]         r_pchg;
    elm_pkg::t_out       r_res;

    logic [31:0]         w_lv_mag;
    logic                w_cp;
    logic                w_cr;
    logic [32:0]         w_rem_sh;
    logic [33:0]         w_diff;
    logic                w_qbit;
    logic signed [49:0]  w_quo;
    logic signed [49:0]  w_eq;
    logic [1:0]          w_band;
    logic signed [elm_pkg::GAIN_W-1:0] w_gain;
    logic signed [elm_pkg::OFFS_W-1:0] w_offs;
    logic signed [50:0]  w_cur_sum;
    logic signed [25:0]  n_cur;
    logic signed [45:0]  w_volt_sum;
    logic signed [26:0]  w_x;
    logic signed [24:0]  w_y;
    logic [26:0]         w_z;
    logic signed [58:0]  w_drop_sum;
    logic signed [42:0]  w_drop;
    logic signed [43:0]  w_volt;
    logic signed [31:0]  n_volt;
    logic signed [25:0]  w_step;
    logic signed [48:0]  w_chg;
    logic signed [47:0]  n_charge;

    // setup
    assign w_lv_mag = r_last_volt[31] ? (~r_last_volt + 32'd1) : r_last_volt;
    assign w_cp     = (i_load_mode == elm_pkg::MODE_CP) && (r_last_volt != 32'sd0);
    assign w_cr     = (i_load_mode == elm_pkg::MODE_CR) && (i_setpoint != 32'd0);
    assign o_sts.use_div = w_cp || w_cr;

    // restoring division step
    assign w_rem_sh = {r_rem, r_num[47]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_den};
    assign w_qbit   = !w_diff[33];

    // equivalent current and band
    assign w_quo = $signed({2'b00, r_num});
    assign w_eq  = r_use_div ? (r_neg ? -w_quo : w_quo) : $signed({18'd0, i_setpoint});

    always_comb begin
        if (w_eq < 50'sd0) begin
            w_band = elm_pkg::BAND_OUT;
        end else if (w_eq <= elm_pkg::EQ_LIM_LOW) begin
            w_band = elm_pkg::BAND_LOW;
        end else if (w_eq <= elm_pkg::EQ_LIM_MID) begin
            w_band = elm_pkg::BAND_MID;
        end else if (w_eq <= elm_pkg::EQ_LIM_HIGH) begin
            w_band = elm_pkg::BAND_HIGH;
        end else begin
            w_band = elm_pkg::BAND_OUT;
        end
    end

    always_comb begin
        case (w_band)
            elm_pkg::BAND_LOW: w_gain = elm_pkg::GAIN0;
            elm_pkg::BAND_MID: w_gain = elm_pkg::GAIN1;
            default:           w_gain = elm_pkg::GAIN2;
        endcase
    end

    always_comb begin
        case (r_band)
            elm_pkg::BAND_LOW: w_offs = elm_pkg::OFFS0;
            elm_pkg::BAND_MID: w_offs = elm_pkg::OFFS1;
            default:           w_offs = elm_pkg::OFFS2;
        endcase
    end

    // round Q40 to Q16; calibrated current stays within 26 bits
    assign w_cur_sum  = 51'(r_pcur) + 51'(w_offs) + 51'sd8388608;
    assign n_cur      = (i_load_on && (r_band != elm_pkg::BAND_OUT)) ? w_cur_sum[49:24] : 26'sd0;
    assign w_volt_sum = 46'(r_pvolt) + 46'(elm_pkg::OFFSV) + 46'sd8388608;

    // charge step operand
    assign w_x = 27'(r_cur) + 27'sd10;
    assign w_y = w_x[26:2];
    assign w_z = 27'(w_y) + elm_pkg::CHG_BIAS;

    // final voltage and charge
    assign w_drop_sum = r_pdrop + 59'sd32768;
    assign w_drop     = w_drop_sum[58:16];
    assign w_volt     = 44'(r_volt0) + (i_load_on ? 44'(w_drop) : 44'sd0);

    always_comb begin
        if (w_volt > 44'sd2147483647) begin
            n_volt = 32'sh7FFFFFFF;
        end else if (w_volt < -44'sd2147483648) begin
            n_volt = 32'sh80000000;
        end else begin
            n_volt = w_volt[31:0];
        end
    end

    assign w_step = $signed({1'b0, r_pchg[53:29]}) - 26'sd16777216;
    assign w_chg  = 49'(r_charge) + 49'(w_step);

    always_comb begin
        if (!i_load_on) begin
            n_charge = 48'sd0;
        end else if (w_chg > 49'sd140737488355327) begin
            n_charge = 48'sh7FFFFFFFFFFF;
        end else if (w_chg < -49'sd140737488355328) begin
            n_charge = 48'sh800000000000;
        end else begin
            n_charge = w_chg[47:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rc      <= i_in_item.raw_current;
            r_rv      <= i_in_item.raw_voltage;
            r_use_div <= w_cp || w_cr;
            r_neg     <= r_last_volt[31];
            r_num     <= w_cp ? {i_setpoint, 16'd0} : {w_lv_mag, 16'd0};
            r_den     <= w_cp ? w_lv_mag : i_setpoint;
            r_rem     <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_qbit ? w_diff[31:0] : w_rem_sh[31:0];
            r_num <= {r_num[46:0], w_qbit};
        end
        if (i_cmd.cal) begin
            r_band  <= w_band;
            r_rel1  <= w_eq > elm_pkg::EQ_LIM_LOW;
            r_rel2  <= w_eq > elm_pkg::EQ_LIM_RELAY2;
            r_pcur  <= r_rc * w_gain;
            r_pvolt <= r_rv * elm_pkg::GAINV;
        end
        if (i_cmd.cur) begin
            r_cur   <= n_cur;
            r_volt0 <= w_volt_sum[45:24];
        end
        if (i_cmd.drop) begin
            r_pdrop <= r_cur * $signed({1'b0, i_wire_res});
            r_pchg  <= w_z * elm_pkg::CHG_M;
        end
        if (i_cmd.fin) begin
            r_res.current_value    <= 32'(r_cur);
            r_res.voltage_value    <= n_volt;
            r_res.relay_one        <= r_rel1;
            r_res.relay_two        <= r_rel2;
            r_res.calibration_band <= r_band;
            r_res.charge_value     <= n_charge;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_volt <= '0;
            r_charge    <= '0;
        end else if (i_cmd.fin) begin
            r_last_volt <= n_volt;
            r_charge    <= n_charge;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire
